[design/pli_pkg.sv]
package pli_pkg;

  localparam int MAX_POINTS = 3;
  localparam int DATA_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STEPS  = DATA_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef logic signed [DATA_W-1:0] q16_t;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_X0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_X1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_X2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_Y0    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_Y1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_Y2    = 3'd6;

  localparam logic [1:0] KIND_INTERP = 2'd0;
  localparam logic [1:0] KIND_BELOW  = 2'd1;
  localparam logic [1:0] KIND_ABOVE  = 2'd2;

  typedef struct packed {
    logic [1:0]                 point_count;
    q16_t [MAX_POINTS-1:0]      break_x;
    q16_t [MAX_POINTS-1:0]      value_y;
  } pli_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pli_div_status_t;

endpackage

[design/pli_if.sv]
interface pli_sample_if;
  import pli_pkg::*;

  logic valid;
  logic ready;
  q16_t x_sample;

  modport source (output valid, output x_sample, input ready);
  modport sink (input valid, input x_sample, output ready);
endinterface

interface pli_result_if;
  import pli_pkg::*;

  logic       valid;
  logic       ready;
  q16_t       y_result;
  logic [1:0] segment_index;
  logic [1:0] clamp_kind;

  modport source (output valid, output y_result, output segment_index, output clamp_kind,
                  input ready);
  modport sink (input valid, input y_result, input segment_index, input clamp_kind,
                output ready);
endinterface

[design/pli_cfg_regs.sv]
module pli_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pli_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pli_pkg::DATA_W-1:0]        cfg_data,
  output pli_pkg::pli_cfg_t                 cfg
);
  import pli_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point_count <= 2'd3;
      cfg.break_x[0]  <= 24'sd25600;
      cfg.break_x[1]  <= 24'sd76800;
      cfg.break_x[2]  <= 24'sd128000;
      cfg.value_y[0]  <= 24'sd65280;
      cfg.value_y[1]  <= 24'sd65280;
      cfg.value_y[2]  <= 24'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_COUNT: cfg.point_count <= cfg_data[1:0];
        REG_BREAK_X0:    cfg.break_x[0]  <= cfg_data;
        REG_BREAK_X1:    cfg.break_x[1]  <= cfg_data;
        REG_BREAK_X2:    cfg.break_x[2]  <= cfg_data;
        REG_VALUE_Y0:    cfg.value_y[0]  <= cfg_data;
        REG_VALUE_Y1:    cfg.value_y[1]  <= cfg_data;
        REG_VALUE_Y2:    cfg.value_y[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[design/pli_divider.sv]
module pli_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [2*pli_pkg::DATA_W-1:0]    dividend,
  input  logic [pli_pkg::DATA_W-1:0]      divisor,
  output logic [pli_pkg::DATA_W-1:0]      quotient,
  output pli_pkg::pli_div_status_t        status
);
  import pli_pkg::*;

  // The quotient is known to fit in DATA_W bits, so the upper half of the
  // dividend is already below the divisor and seeds the remainder.
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    work;
  logic [DATA_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;
  logic                 done;

  logic [DATA_W:0] shifted;
  logic [DATA_W:0] diff;
  logic            ge;

  always_comb begin
    shifted = {rem, work[DATA_W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= dividend[2*DATA_W-1:DATA_W];
        work  <= dividend[DATA_W-1:0];
        dvs   <= divisor;
        count <= DIV_CNT_W'(DIV_STEPS);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        work  <= {work[DATA_W-2:0], ge};
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = work;
  assign status.busy = busy;
  assign status.done = done;

  a_busy_has_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0)
    else $error("divider busy with no steps left");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without running");

endmodule

[design/piecewise_linear_interp_unit.sv]
// Piecewise linear curve evaluator with clamping at both ends.
// The sample channel carries one signed Q16.8 abscissa per transfer; the
// result channel returns one transfer per sample with the Q16.8 value, the
// index of the upper breakpoint used and a clamp code.
// The curve (point count, three breakpoints and their values) is written
// through the configuration port: write enable, register index, 24-bit data.
// Writes to an index beyond the list are ignored.
// One sample is processed at a time. The breakpoint search takes one compare
// per cycle. A clamped sample then passes through the finish state to reach
// the output register. An interpolated sample adds a setup state, a multiply
// state and the 24 steps of the restoring divider before the finish state.
// The next sample is taken in the cycle after a result is loaded, so the
// 24-step divider dominates the time taken by an interpolated sample.
// The sample channel is ready only while the sequencer is idle. A result
// held in the output register does not block the next sample; if the
// receiver is still stalling when the next result is done, the sequencer
// waits in its final state until the output register frees.
// Reset restores the default curve and empties the output register.
module piecewise_linear_interp_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pli_pkg::DATA_W-1:0]     cfg_data,
  pli_sample_if.sink                     sample,
  pli_result_if.source                   result
);
  import pli_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_SETUP  = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  pli_cfg_t        cfg;
  pli_div_status_t div_stat;

  q16_t              x_val;
  logic [1:0]        hi;
  q16_t              y_res;
  logic [1:0]        seg;
  logic [1:0]        kind;
  logic [DATA_W-1:0] dx;
  logic [DATA_W-1:0] dd;
  logic [DATA_W-1:0] dy_mag;
  logic              dy_neg;
  logic [DATA_W-1:0] quotient;

  logic              out_valid;
  q16_t              out_y;
  logic [1:0]        out_seg;
  logic [1:0]        out_kind;

  logic [1:0]          n_eff;
  logic [1:0]          lo;
  q16_t                bx_hi;
  logic                search_hit;
  logic                div_start;
  logic [2*DATA_W-1:0] product;
  logic [DATA_W:0]     dx_w;
  logic [DATA_W:0]     dd_w;
  logic [DATA_W:0]     dy_w;
  logic [DATA_W:0]     dy_abs;
  logic [DATA_W:0]     q_signed;
  logic [DATA_W+1:0]   y_sum;
  q16_t                y_final;
  logic                out_free;

  pli_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pli_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (dd),
    .quotient (quotient),
    .status   (div_stat)
  );

  always_comb begin
    if (cfg.point_count == 2'd0) begin
      n_eff = 2'd1;
    end else if (cfg.point_count > 2'(MAX_POINTS)) begin
      n_eff = 2'(MAX_POINTS);
    end else begin
      n_eff = cfg.point_count;
    end

    case (hi)
      2'd0:    bx_hi = cfg.break_x[0];
      2'd1:    bx_hi = cfg.break_x[1];
      2'd2:    bx_hi = cfg.break_x[2];
      default: bx_hi = cfg.break_x[2];
    endcase
    search_hit = (hi != n_eff) && ($signed(x_val) > $signed(bx_hi));

    lo     = hi - 2'd1;
    dx_w   = {x_val[DATA_W-1], x_val} - {cfg.break_x[lo][DATA_W-1], cfg.break_x[lo]};
    dd_w   = {bx_hi[DATA_W-1], bx_hi} - {cfg.break_x[lo][DATA_W-1], cfg.break_x[lo]};
    dy_w   = {cfg.value_y[hi][DATA_W-1], cfg.value_y[hi]}
             - {cfg.value_y[lo][DATA_W-1], cfg.value_y[lo]};
    dy_abs = dy_w[DATA_W] ? -dy_w : dy_w;

    div_start = (state == ST_MUL);
    product   = dx * dy_mag;

    q_signed = dy_neg ? -{1'b0, quotient} : {1'b0, quotient};
    y_sum    = {{2{y_res[DATA_W-1]}}, y_res} + {q_signed[DATA_W], q_signed};
    if (y_sum[DATA_W+1:DATA_W-1] == 3'b000 || y_sum[DATA_W+1:DATA_W-1] == 3'b111) begin
      y_final = y_sum[DATA_W-1:0];
    end else if (y_sum[DATA_W+1]) begin
      y_final = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y_final = {1'b0, {(DATA_W-1){1'b1}}};
    end

    out_free = !out_valid || result.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            x_val <= sample.x_sample;
            hi    <= 2'd0;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (search_hit) begin
            hi <= hi + 2'd1;
          end else if (hi == 2'd0) begin
            y_res <= cfg.value_y[0];
            seg   <= 2'd0;
            kind  <= KIND_BELOW;
            state <= ST_FINISH;
          end else if (hi == n_eff) begin
            y_res <= cfg.value_y[n_eff - 2'd1];
            seg   <= n_eff - 2'd1;
            kind  <= KIND_ABOVE;
            state <= ST_FINISH;
          end else begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          dx     <= dx_w[DATA_W-1:0];
          dd     <= dd_w[DATA_W-1:0];
          dy_neg <= dy_w[DATA_W];
          dy_mag <= dy_abs[DATA_W-1:0];
          y_res  <= cfg.value_y[lo];
          seg    <= hi;
          kind   <= KIND_INTERP;
          state  <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            y_res <= y_final;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_y     <= y_res;
            out_seg   <= seg;
            out_kind  <= kind;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign sample.ready         = (state == ST_IDLE);
  assign result.valid         = out_valid;
  assign result.y_result      = out_y;
  assign result.segment_index = out_seg;
  assign result.clamp_kind    = out_kind;

  a_div_runs_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  a_interp_upper_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.clamp_kind == KIND_INTERP) |-> result.segment_index != 2'd0)
    else $error("interpolated result with lower clamp segment");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    ($past(state == ST_FINISH) && $past(out_valid) && !$past(result.ready))
    |-> (state == ST_FINISH))
    else $error("result overwritten while receiver stalls");

endmodule

[dv/tb_piecewise_linear_interp_unit.sv]
`timescale 1ns / 1ps

module tb_piecewise_linear_interp_unit;
  import pli_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam q16_t Q_MAX = 24'sh7FFFFF;
  localparam q16_t Q_MIN = 24'sh800000;
  localparam int DRAIN_CYCLES = 48;

  typedef struct packed {
    q16_t       y;
    logic [1:0] seg;
    logic [1:0] kind;
  } curve_out_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  pli_sample_if sample_ch ();
  pli_result_if result_ch ();

  piecewise_linear_interp_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  logic [1:0] cur_count;
  q16_t       cur_bx [MAX_POINTS];
  q16_t       cur_by [MAX_POINTS];

  q16_t       x_todo_q [$];
  curve_out_t curve_out_q [$];
  int         samples_queued;
  int         results_seen;
  int         fails;
  int         gap_left;
  int         stall_left;
  bit         calm;
  curve_out_t want;

  always #10 clk = ~clk;

  function automatic curve_out_t eval_curve(q16_t x);
    curve_out_t r;
    int n;
    int hi;
    longint dx;
    longint dy;
    longint dd;
    longint yv;
    n = (cur_count == 2'd0) ? 1 : int'(cur_count);
    hi = 0;
    while (hi < n && x > cur_bx[hi]) hi++;
    if (hi == 0) begin
      r.y = cur_by[0];
      r.seg = 2'd0;
      r.kind = KIND_BELOW;
    end else if (hi == n) begin
      r.y = cur_by[n-1];
      r.seg = 2'(n - 1);
      r.kind = KIND_ABOVE;
    end else begin
      dx = longint'(x) - longint'(cur_bx[hi-1]);
      dy = longint'(cur_by[hi]) - longint'(cur_by[hi-1]);
      dd = longint'(cur_bx[hi]) - longint'(cur_bx[hi-1]);
      if (dd <= 0) dd = 1;
      yv = longint'(cur_by[hi-1]) + (dx * dy) / dd;
      if (yv > longint'(Q_MAX)) yv = longint'(Q_MAX);
      if (yv < longint'(Q_MIN)) yv = longint'(Q_MIN);
      r.y = q16_t'(yv);
      r.seg = 2'(hi);
      r.kind = KIND_INTERP;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 80);
    return $urandom_range(1, 4);
  endfunction

  function automatic q16_t rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return Q_MAX;
    if (r == 1) return Q_MIN;
    if (r < 5) return q16_t'(int'($urandom_range(0, 200000)) - 100000);
    return q16_t'($urandom);
  endfunction

  function automatic q16_t rand_x();
    int r;
    longint lo;
    longint hi;
    int k;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, MAX_POINTS - 1);
    if (r < 2) return q16_t'($urandom);
    if (r == 2) return cur_bx[k];
    if (r == 3) return ($urandom_range(0, 1) == 1) ? cur_bx[k] + 24'sd1 : cur_bx[k] - 24'sd1;
    lo = cur_bx[0];
    hi = cur_bx[0];
    for (int i = 1; i < MAX_POINTS; i++) begin
      if (cur_bx[i] < lo) lo = cur_bx[i];
      if (cur_bx[i] > hi) hi = cur_bx[i];
    end
    lo = lo - 2000;
    hi = hi + 2000;
    if (lo < longint'(Q_MIN)) lo = longint'(Q_MIN);
    if (hi > longint'(Q_MAX)) hi = longint'(Q_MAX);
    return q16_t'(lo + longint'($urandom_range(0, int'(hi - lo))));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_POINT_COUNT: cur_count = data[1:0];
      REG_BREAK_X0: cur_bx[0] = data;
      REG_BREAK_X1: cur_bx[1] = data;
      REG_BREAK_X2: cur_bx[2] = data;
      REG_VALUE_Y0: cur_by[0] = data;
      REG_VALUE_Y1: cur_by[1] = data;
      REG_VALUE_Y2: cur_by[2] = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_x(q16_t x);
    x_todo_q.push_back(x);
    samples_queued++;
  endtask

  task automatic drain();
    while (results_seen < samples_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_curve(logic [1:0] cnt, q16_t x0, q16_t x1, q16_t x2,
                            q16_t y0, q16_t y1, q16_t y2);
    write_reg(REG_POINT_COUNT, DATA_W'(cnt));
    write_reg(REG_BREAK_X0, x0);
    write_reg(REG_BREAK_X1, x1);
    write_reg(REG_BREAK_X2, x2);
    write_reg(REG_VALUE_Y0, y0);
    write_reg(REG_VALUE_Y1, y1);
    write_reg(REG_VALUE_Y2, y2);
  endtask

  task automatic random_curve();
    int mode;
    int r;
    int b0;
    int b1;
    int b2;
    int t;
    logic [1:0] cnt;
    mode = $urandom_range(0, 9);
    b0 = int'($urandom_range(0, 200000)) - 100000;
    if (mode < 5) begin
      b1 = b0 + int'($urandom_range(1, 30000));
      b2 = b1 + int'($urandom_range(1, 30000));
    end else if (mode == 5) begin
      b1 = b0 + 1;
      b2 = b1 + int'($urandom_range(1, 3));
    end else if (mode < 8) begin
      b0 = int'(q16_t'($urandom));
      b1 = int'(q16_t'($urandom));
      b2 = int'(q16_t'($urandom));
      if (b1 < b0) begin t = b0; b0 = b1; b1 = t; end
      if (b2 < b1) begin t = b1; b1 = b2; b2 = t; end
      if (b1 < b0) begin t = b0; b0 = b1; b1 = t; end
      if (b1 == b0) b1 = b0 + 1;
      if (b2 <= b1) b2 = b1 + 1;
    end else if (mode == 8) begin
      b0 = int'(Q_MIN);
      b1 = int'(q16_t'($urandom));
      b2 = int'(Q_MAX);
    end else begin
      b1 = int'($urandom_range(0, 200000)) - 100000;
      b2 = int'($urandom_range(0, 200000)) - 100000;
    end
    r = $urandom_range(0, 9);
    cnt = (r == 0) ? 2'd0 : (r == 1) ? 2'd1 : (r < 4) ? 2'd2 : 2'd3;
    load_curve(cnt, q16_t'(b0), q16_t'(b1), q16_t'(b2),
               rand_value(), rand_value(), rand_value());
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, DATA_W'($urandom));
    end_writes();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.x_sample <= '0;
      gap_left <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        curve_out_q.push_back(eval_curve(sample_ch.x_sample));
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (gap_left > 0 || x_todo_q.size() == 0) begin
          sample_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          sample_ch.valid <= 1'b1;
          sample_ch.x_sample <= x_todo_q.pop_front();
          gap_left <= pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (curve_out_q.size() == 0) begin
          $error("result transfer with no sample outstanding");
          fails++;
        end else begin
          want = curve_out_q.pop_front();
          if (result_ch.y_result !== want.y) begin
            $error("y_result: expected %0d, got %0d", want.y, $signed(result_ch.y_result));
            fails++;
          end
          if (result_ch.segment_index !== want.seg) begin
            $error("segment_index: expected %0d, got %0d", want.seg, result_ch.segment_index);
            fails++;
          end
          if (result_ch.clamp_kind !== want.kind) begin
            $error("clamp_kind: expected %0d, got %0d", want.kind, result_ch.clamp_kind);
            fails++;
          end
        end
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        result_ch.ready <= 1'b0;
        stall_left <= pick_stall();
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #25_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.x_sample = '0;
    result_ch.ready = 1'b0;
    samples_queued = 0;
    results_seen = 0;
    fails = 0;
    calm = 1'b0;
    cur_count = 2'd3;
    cur_bx[0] = 24'sd25600;
    cur_bx[1] = 24'sd76800;
    cur_bx[2] = 24'sd128000;
    cur_by[0] = 24'sd65280;
    cur_by[1] = 24'sd65280;
    cur_by[2] = 24'sd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // The default curve: clamps at both ends and exact hits on every breakpoint.
    push_x(Q_MIN);
    push_x(Q_MAX);
    push_x(24'sd0);
    push_x(24'sd25600);
    push_x(24'sd25601);
    push_x(24'sd50000);
    push_x(24'sd76800);
    push_x(24'sd76801);
    push_x(24'sd100000);
    push_x(24'sd128000);
    push_x(24'sd128001);
    drain();

    // A zero point count acts as a single point; the write to the unused index is dropped.
    load_curve(2'd0, 24'sd0, 24'sd500, 24'sd900, 24'sd1234, 24'sd77, 24'sd99);
    write_reg(REG_UNUSED, 24'hABCDEF);
    end_writes();
    push_x(-24'sd1);
    push_x(24'sd0);
    push_x(24'sd1);
    drain();

    // Breakpoints and values at the ends of the range.
    load_curve(2'd2, Q_MIN, Q_MAX, 24'sd0, Q_MIN, Q_MAX, Q_MIN);
    end_writes();
    push_x(Q_MIN);
    push_x(Q_MAX);
    push_x(24'sd0);
    push_x(Q_MIN + 24'sd1);
    push_x(Q_MAX - 24'sd1);
    drain();

    // Breakpoints out of order keep the same scan rule.
    load_curve(2'd3, 24'sd1000, 24'sd500, 24'sd2000, Q_MAX, 24'sd300, Q_MIN);
    end_writes();
    push_x(24'sd600);
    push_x(24'sd1200);
    push_x(24'sd3000);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph % 4 == 3);
      random_curve();
      for (int i = 0; i < 104; i++) push_x(rand_x());
      drain();
    end

    if (curve_out_q.size() != 0) begin
      $error("%0d expected results never arrived", curve_out_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[piecewise_linear_interp_unit.f]
design/pli_pkg.sv
design/pli_if.sv
design/pli_cfg_regs.sv
design/pli_divider.sv
design/piecewise_linear_interp_unit.sv
dv/tb_piecewise_linear_interp_unit.sv
